// ===== rtl/core/spimr_pkg.sv =====
package spimr_pkg;

    // Select lines on the port; the parameter limits how many are live
    localparam int SEL_PINS         = 4;
    localparam int CHIP_SELECTS_DEF = 4;

    localparam int ADDR_W = 12;
    localparam int BYTE_W = 8;
    localparam int FLAG_W = 4;

    // Access direction
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register offsets in the window
    localparam logic [ADDR_W-1:0] ADDR_CR1    = 12'h000;
    localparam logic [ADDR_W-1:0] ADDR_CR2    = 12'h004;
    localparam logic [ADDR_W-1:0] ADDR_SR     = 12'h008;
    localparam logic [ADDR_W-1:0] ADDR_DR     = 12'h00C;
    localparam logic [ADDR_W-1:0] ADDR_CSCTRL = 12'h010;

    // Status flag positions (same as SR bit positions)
    localparam int FLAG_RXNE  = 0;
    localparam int FLAG_TXE   = 1;
    localparam int FLAG_UNDER = 2;
    localparam int FLAG_OVER  = 3;

    // Control bit positions
    localparam int CR1_ENABLE = 6;
    localparam int IE_ERR     = 5;
    localparam int IE_RXNE    = 6;
    localparam int IE_TXE     = 7;

    // Reset values
    localparam logic [FLAG_W-1:0] FLAGS_RESET = 4'h2;
    localparam logic [BYTE_W-1:0] DR_RESET    = 8'h0C;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
        logic [BYTE_W-1:0] write_data;
        logic [BYTE_W-1:0] slave_rx_byte;
    } req_beat_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_data;
        logic                irq;
        logic [SEL_PINS-1:0] chip_select_n;
        logic                transfer_strobe;
        logic [BYTE_W-1:0]   tx_byte;
    } rsp_beat_t;

    // One access handed to the register file
    typedef struct packed {
        logic      fire;
        req_beat_t beat;
    } access_t;

endpackage

// ===== rtl/core/spimr_stream_if.sv =====
interface spimr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/spimr_regs.sv =====
module spimr_regs
    import spimr_pkg::*;
#(
    parameter int CHIP_SELECTS = CHIP_SELECTS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  access_t   acc,
    output rsp_beat_t result
);

    localparam logic [SEL_PINS-1:0] SEL_MASK = SEL_PINS'((1 << CHIP_SELECTS) - 1);

    logic [BYTE_W-1:0] cr1_reg, cr1_next;
    logic [BYTE_W-1:0] cr2_reg, cr2_next;
    logic [FLAG_W-1:0] flags_reg, flags_next;
    logic [BYTE_W-1:0] data_reg, data_next;
    logic [BYTE_W-1:0] sel_reg, sel_next;

    logic [SEL_PINS-1:0] live_now;
    logic [SEL_PINS-1:0] live_after;
    logic [BYTE_W-1:0]   rdata;
    logic                strobe;
    logic [BYTE_W-1:0]   txb;
    logic                irq_after;

    // Decode the access and work out the next register state
    always_comb
    begin
        cr1_next   = cr1_reg;
        cr2_next   = cr2_reg;
        flags_next = flags_reg;
        data_next  = data_reg;
        sel_next   = sel_reg;
        rdata      = '0;
        strobe     = 1'b0;
        txb        = '0;
        live_now   = sel_reg[SEL_PINS-1:0] & sel_reg[2*SEL_PINS-1:SEL_PINS] & SEL_MASK;

        if (acc.fire)
        begin
            if (acc.beat.operation == OP_READ)
            begin
                case (acc.beat.address)
                    ADDR_CR1:    rdata = cr1_reg;
                    ADDR_CR2:    rdata = cr2_reg;
                    ADDR_SR:     rdata = {{(BYTE_W-FLAG_W){1'b0}}, flags_reg};
                    ADDR_DR:
                    begin
                        // Consume the received byte, or flag underrun
                        if (!flags_reg[FLAG_RXNE])
                        begin
                            flags_next[FLAG_UNDER] = 1'b1;
                        end
                        else
                        begin
                            rdata                 = data_reg;
                            flags_next[FLAG_RXNE] = 1'b0;
                        end
                    end
                    ADDR_CSCTRL: rdata = sel_reg;
                    default:     rdata = '0;
                endcase
            end
            else
            begin
                case (acc.beat.address)
                    ADDR_CR1:    cr1_next = acc.beat.write_data;
                    ADDR_CR2:    cr2_next = acc.beat.write_data;
                    ADDR_SR:
                    begin
                        // Write one to clear the error flags
                        flags_next[FLAG_UNDER] = flags_reg[FLAG_UNDER]
                                                 & ~acc.beat.write_data[FLAG_UNDER];
                        flags_next[FLAG_OVER]  = flags_reg[FLAG_OVER]
                                                 & ~acc.beat.write_data[FLAG_OVER];
                    end
                    ADDR_DR:
                    begin
                        if (cr1_reg[CR1_ENABLE])
                        begin
                            if (flags_reg[FLAG_RXNE] || !flags_reg[FLAG_TXE])
                            begin
                                flags_next[FLAG_OVER] = 1'b1;
                            end
                            data_next = acc.beat.write_data;
                            // Exchange the byte when any select is live
                            if (live_now != '0)
                            begin
                                strobe                = 1'b1;
                                txb                   = acc.beat.write_data;
                                data_next             = acc.beat.slave_rx_byte;
                                flags_next[FLAG_RXNE] = 1'b1;
                            end
                            else
                            begin
                                flags_next[FLAG_RXNE] = 1'b0;
                            end
                            flags_next[FLAG_TXE] = 1'b1;
                        end
                    end
                    ADDR_CSCTRL: sel_next = acc.beat.write_data;
                    default:     sel_next = sel_reg;
                endcase
            end
        end

        live_after = sel_next[SEL_PINS-1:0] & sel_next[2*SEL_PINS-1:SEL_PINS] & SEL_MASK;
        irq_after  = (cr2_next[IE_ERR]  && (flags_next[FLAG_OVER] || flags_next[FLAG_UNDER]))
                  || (cr2_next[IE_TXE]  && flags_next[FLAG_TXE])
                  || (cr2_next[IE_RXNE] && flags_next[FLAG_RXNE]);
    end

    // Result seen after this access
    always_comb
    begin
        result.read_data       = rdata;
        result.irq             = irq_after;
        result.chip_select_n   = ~live_after;
        result.transfer_strobe = strobe;
        result.tx_byte         = txb;
    end

    // Hold the register state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr1_reg   <= '0;
            cr2_reg   <= '0;
            flags_reg <= FLAGS_RESET;
            data_reg  <= DR_RESET;
            sel_reg   <= '0;
        end
        else
        begin
            cr1_reg   <= cr1_next;
            cr2_reg   <= cr2_next;
            flags_reg <= flags_next;
            data_reg  <= data_next;
            sel_reg   <= sel_next;
        end
    end

endmodule

// ===== rtl/core/spi_master_register_block.sv =====
// Channel  Dir  Beat                                          Handshake
// req      in   operation, address, write_data, slave_rx_byte valid/ready
// rsp      out  read_data, irq, chip_select_n,                 valid/ready
//               transfer_strobe, tx_byte
//
// An accepted access waits in the input register, then the register file
// updates and the result is registered. One access is accepted every cycle
// unless rsp stalls; the input register and the result register form a
// two-deep pipeline that advances whenever rsp is free. Reset (rst_n low,
// asynchronous) empties both stages and loads the register reset values.
// A stall on rsp backs up through the input stage to req.
module spi_master_register_block
    import spimr_pkg::*;
#(
    parameter int CHIP_SELECTS = CHIP_SELECTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    spimr_stream_if.sink   req,
    spimr_stream_if.source rsp
);

    logic      in_valid_reg;
    req_beat_t in_beat_reg;
    logic      out_valid_reg;
    rsp_beat_t out_beat_reg;

    logic      out_load;
    logic      in_load;
    access_t   acc;
    rsp_beat_t result;

    // Advance the pipeline whenever the result slot is free or draining
    assign out_load  = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || out_load;
    assign in_load   = req.valid && req.ready;

    assign acc.fire = out_load;
    assign acc.beat = in_beat_reg;

    spimr_regs #(
        .CHIP_SELECTS (CHIP_SELECTS)
    ) u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .acc    (acc),
        .result (result)
    );

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_beat_reg <= req.data;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || rsp.ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_beat_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_beat_reg;

`ifndef SYNTHESIS
    localparam logic [SEL_PINS-1:0] CS_KEEP = SEL_PINS'((1 << CHIP_SELECTS) - 1);

    // A transfer only happens with a live select, which the beat still shows
    a_strobe_has_select: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_beat_reg.transfer_strobe |-> out_beat_reg.chip_select_n != '1)
        else $error("transfer without a live select");

    // The sent byte is zero unless a transfer happened
    a_tx_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_beat_reg.transfer_strobe |-> out_beat_reg.tx_byte == '0)
        else $error("tx_byte nonzero without transfer");

    // Select lines beyond the configured count stay inactive
    a_unused_selects_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> &(out_beat_reg.chip_select_n | CS_KEEP))
        else $error("unused select line driven low");

    // A stalled result holds its place while the input stage waits
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !rsp.ready |=> in_valid_reg && out_valid_reg)
        else $error("pipeline dropped a beat under stall");
`endif

endmodule
